// ===== sv/lrukv_pkg.sv =====
// ----------------------------------------------------------------------------
// lrukv_pkg: shared types and constants for the LRU key/value cache
// Field widths, operation codes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lrukv_pkg;

  localparam int KEY_W           = 32;
  localparam int VALUE_W         = 31;
  localparam int RDATA_W         = 32;
  localparam int CAP_W           = 5;
  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // request operation codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== sv/lrukv_req_if.sv =====
// ----------------------------------------------------------------------------
// lrukv_req_if: request channel of the LRU key/value cache
// Valid/ready handshake carrying one get or set request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrukv_req_if;
  import lrukv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [KEY_W-1:0]   key;
  logic        [VALUE_W-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

`default_nettype wire

// ===== sv/lrukv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lrukv_rsp_if: response channel of the LRU key/value cache
// Valid/ready handshake carrying the hit flag and the read value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrukv_rsp_if;
  import lrukv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [RDATA_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

`default_nettype wire

// ===== sv/lrukv_ram.sv =====
// ----------------------------------------------------------------------------
// lrukv_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key/value cache, LRU replacement
//
// Channels: req (sink) takes {action, key, value}; action get looks up the
// key, action set inserts or updates it. rsp (source) returns one response
// per request: hit = key was present, read_value = stored value on a get
// hit, -1 otherwise. A request is taken when valid and ready are both high.
// capacity_we/capacity_wdata write the capacity register (0 acts as 1,
// values above MAX_ENTRIES act as MAX_ENTRIES); write it only while idle.
//
// Operation: one sequencer walks the entry RAMs with a single read port.
// A scan pass finds the key match, the least recent entry and the first
// free slot; a rank pass ages entries and makes the target most recent.
// Get misses skip the rank pass. Ready is high only while idle, so a new
// request is taken only once the sequencer has loaded the finished
// response into the output register. That register lets the next request
// be taken while an earlier response still waits. If rsp stalls, the
// sequencer holds the finished response until the register frees up.
// Reset (synchronous, active high) empties the cache, sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top #(
  parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  lrukv_req_if.sink                        req,
  lrukv_rsp_if.source                      rsp,
  input  wire logic                        capacity_we,
  input  wire logic [lrukv_pkg::CAP_W-1:0] capacity_wdata
);
  import lrukv_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_ENTRIES);

  // sequencer and control state
  state_t                 state, state_next;
  logic [CAP_W-1:0]       capacity;
  logic [MAX_ENTRIES-1:0] valid;          // one flop per entry
  logic [CNT_W-1:0]       valid_count;
  logic [CNT_W-1:0]       cnt;            // RAM walk address, runs to LAST
  logic                   pvld;           // read data in flight is real
  logic [IDX_W-1:0]       pidx;           // entry index of read data
  logic                   rsp_valid;

  // request capture
  logic                   req_action;
  logic [KEY_W-1:0]       req_key;
  logic [VALUE_W-1:0]     req_value;

  // scan results
  logic                   hit;
  logic [IDX_W-1:0]       found_idx;
  logic [IDX_W-1:0]       found_rank;
  logic [VALUE_W-1:0]     found_value;
  logic                   any;
  logic [IDX_W-1:0]       best_idx;
  logic [IDX_W-1:0]       best_rank;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;

  // rank pass setup
  logic [IDX_W-1:0]       tgt_idx;
  logic [IDX_W-1:0]       old_rank;
  logic                   age_all;

  // response register
  logic                   rsp_hit;
  logic [RDATA_W-1:0]     rsp_read_value;

  // RAM ports
  logic [KEY_W-1:0]       key_rd;
  logic [VALUE_W-1:0]     value_rd;
  logic [IDX_W-1:0]       rank_rd;
  logic                   key_we, value_we, rank_we;
  logic [IDX_W-1:0]       rank_wdata;
  logic [IDX_W-1:0]       rd_addr;

  // control decode
  logic                   req_ready;
  logic                   rsp_load;
  logic                   scan_done, upd_done;
  logic                   full, fill;
  logic [CMP_W-1:0]       cap_ext, eff_cap;
  logic [IDX_W-1:0]       sel_idx;
  logic                   ent_valid;

  // shared rank comparator: max search in scan, age test in rank pass
  logic [IDX_W-1:0]       cmp_b;
  logic                   cmp_gt, cmp_lt;

  assign cmp_b  = (state == ST_SCAN) ? best_rank : old_rank;
  assign cmp_gt = rank_rd > cmp_b;
  assign cmp_lt = rank_rd < cmp_b;

  // effective capacity: zero counts as one, saturate at MAX_ENTRIES
  assign cap_ext = CMP_W'(capacity);
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full      = CMP_W'(valid_count) >= eff_cap;
  assign ent_valid = valid[pidx];
  assign rd_addr   = cnt[IDX_W-1:0];
  assign scan_done = (state == ST_SCAN)   && (cnt == LAST) && !pvld;
  assign upd_done  = (state == ST_UPDATE) && (cnt == LAST) && !pvld;
  // slot a set works on: hit entry, else LRU victim when full, else free slot
  assign sel_idx   = hit ? found_idx : (full ? best_idx : free_idx);
  assign fill      = (req_action == ACT_SET) && !hit && !full;

  // RAM writes: key/value at scan end, ranks during the rank pass
  assign key_we     = scan_done && (req_action == ACT_SET) && !hit;
  assign value_we   = scan_done && (req_action == ACT_SET);
  assign rank_we    = (state == ST_UPDATE) && pvld && ent_valid;
  assign rank_wdata = (pidx == tgt_idx) ? '0 :
                      ((age_all || cmp_lt) ? rank_rd + IDX_W'(1) : rank_rd);

  lrukv_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (sel_idx),
    .wdata (req_key),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  lrukv_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (sel_idx),
    .wdata (req_value),
    .raddr (rd_addr),
    .rdata (value_rd)
  );

  lrukv_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (pidx),
    .wdata (rank_wdata),
    .raddr (rd_addr),
    .rdata (rank_rd)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rsp_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          // get miss leaves recency untouched
          if (!hit && (req_action == ACT_GET)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (upd_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RESET;
      valid       <= '0;
      valid_count <= '0;
      rsp_valid   <= 1'b0;
      cnt         <= '0;
      pvld        <= 1'b0;
    end else begin
      if (capacity_we) begin
        capacity <= capacity_wdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if ((state inside {ST_SCAN, ST_UPDATE}) && !scan_done) begin
        if (cnt != LAST) begin
          cnt  <= cnt + CNT_W'(1);
          pvld <= 1'b1;
        end else begin
          pvld <= 1'b0;
        end
        if (upd_done) begin
          cnt <= '0;
        end
      end else begin
        cnt  <= '0;
        pvld <= 1'b0;
      end
      if (scan_done && fill) begin
        valid[free_idx] <= 1'b1;
        valid_count     <= valid_count + CNT_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pidx <= rd_addr;
    if (req.valid && req_ready) begin
      req_action <= req.action;
      req_key    <= req.key;
      req_value  <= req.value;
      hit        <= 1'b0;
      any        <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == ST_SCAN && pvld) begin
      if (ent_valid && (key_rd == req_key) && !hit) begin
        hit         <= 1'b1;
        found_idx   <= pidx;
        found_rank  <= rank_rd;
        found_value <= value_rd;
      end
      if (ent_valid && (!any || cmp_gt)) begin
        any       <= 1'b1;
        best_idx  <= pidx;
        best_rank <= rank_rd;
      end
      if (!ent_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= pidx;
      end
    end
    if (scan_done) begin
      tgt_idx  <= sel_idx;
      old_rank <= found_rank;
      age_all  <= !hit;     // insertion ages every other entry
    end
    if (rsp_load) begin
      rsp_hit        <= hit;
      rsp_read_value <= (hit && (req_action == ACT_GET)) ?
                        {1'b0, found_value} : '1;
    end
  end

  assign req.ready      = req_ready;
  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_read_value;

  // fill level never exceeds the entry count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CNT_W'(MAX_ENTRIES))
    else $error("valid_count above MAX_ENTRIES");

  // fill level tracks the valid bits
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(valid_count))
    else $error("valid_count out of step with valid bits");

  // a hit always points at a live entry
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && hit) |-> valid[tgt_idx])
    else $error("hit target entry not valid");

  // rank pass runs only for sets or get hits
  a_update_cause: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> (req_action == ACT_SET || hit))
    else $error("rank pass on a get miss");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lru_key_value_cache_top
// Drives get/set requests, checks each response against typed values or a
// shadow LRU cache and sweeps capacity across its range under varied idling.
// ----------------------------------------------------------------------------
module testbench;
  import lrukv_pkg::*;

  localparam int ENTRIES = MAX_ENTRIES_DEF;

  // read_value returned on a get miss and on every set
  localparam logic [RDATA_W-1:0] MISS_VALUE = '1;

  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 130;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 400;
  // scan + rank pass plus the output register, with margin
  localparam int DRAIN_CYCLES   = 2 * ENTRIES + 20;
  // ~1060 requests, worst case gaps and stalls, x10
  localparam int CYCLE_LIMIT    = 500000;

  // capacity used by each random phase; 0 acts as 1, 17 and 31 saturate
  localparam logic [CAP_W-1:0] PHASE_CAPACITY [RANDOM_PHASES] =
    '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd2};

  // one response: the fields the block returns per request
  typedef struct packed {
    logic               hit;
    logic [RDATA_W-1:0] read_value;
  } lookup_result_t;

  // directed rows: a capacity write, a request with its response typed in,
  // or a request checked against the shadow cache
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_TYPED,
    ROW_MODEL
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               act;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;     // capacity on ROW_CFG
    logic               exp_hit;
    logic [RDATA_W-1:0] exp_read;
  } stim_row_t;

  localparam stim_row_t DIRECTED_STIM [26] = '{
    // empty cache after reset, capacity 16
    '{ROW_TYPED, ACT_GET, 32'h0000_0000, 31'h0000_0000, 1'b0, MISS_VALUE},
    '{ROW_TYPED, ACT_SET, 32'h0000_0000, 31'h0000_0000, 1'b0, MISS_VALUE},
    '{ROW_TYPED, ACT_GET, 32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0000_0000},
    // key and value extremes
    '{ROW_TYPED, ACT_SET, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, MISS_VALUE},
    '{ROW_TYPED, ACT_SET, 32'h8000_0000, 31'h0000_0001, 1'b0, MISS_VALUE},
    '{ROW_TYPED, ACT_GET, 32'h8000_0000, 31'h0000_0000, 1'b1, 32'h0000_0001},
    '{ROW_TYPED, ACT_GET, 32'h7FFF_FFFF, 31'h0000_0000, 1'b1, 32'h7FFF_FFFF},
    '{ROW_TYPED, ACT_SET, 32'hFFFF_FFFF, 31'h0000_0005, 1'b0, MISS_VALUE},
    // set hit overwrites; a get ignores its value field
    '{ROW_TYPED, ACT_SET, 32'h0000_0000, 31'h2AAA_AAAA, 1'b1, MISS_VALUE},
    '{ROW_TYPED, ACT_GET, 32'h0000_0000, 31'h7FFF_FFFF, 1'b1, 32'h2AAA_AAAA},
    // capacity dropped below the fill level: a set miss evicts one entry
    '{ROW_CFG,   ACT_GET, 32'h0000_0000, 31'd2,         1'b0, '0},
    '{ROW_MODEL, ACT_SET, 32'h0000_1234, 31'h0000_0009, 1'b0, '0},
    '{ROW_MODEL, ACT_GET, 32'h8000_0000, 31'h0000_0000, 1'b0, '0},
    '{ROW_MODEL, ACT_GET, 32'h0000_1234, 31'h0000_0000, 1'b0, '0},
    // capacity zero acts as one
    '{ROW_CFG,   ACT_GET, 32'h0000_0000, 31'd0,         1'b0, '0},
    '{ROW_MODEL, ACT_SET, 32'hA5A5_A5A5, 31'h5555_5555, 1'b0, '0},
    '{ROW_TYPED, ACT_GET, 32'hA5A5_A5A5, 31'h0000_0000, 1'b1, 32'h5555_5555},
    '{ROW_MODEL, ACT_SET, 32'h5A5A_5A5A, 31'h0000_0003, 1'b0, '0},
    '{ROW_MODEL, ACT_GET, 32'hA5A5_A5A5, 31'h0000_0000, 1'b0, '0},
    // capacity above the entry count saturates; misses take free slots
    '{ROW_CFG,   ACT_GET, 32'h0000_0000, 31'd31,        1'b0, '0},
    '{ROW_MODEL, ACT_SET, 32'h0000_0100, 31'h0000_0010, 1'b0, '0},
    '{ROW_MODEL, ACT_SET, 32'h0000_0101, 31'h0000_0011, 1'b0, '0},
    '{ROW_CFG,   ACT_GET, 32'h0000_0000, 31'd17,        1'b0, '0},
    '{ROW_MODEL, ACT_SET, 32'h0000_0102, 31'h0000_0012, 1'b0, '0},
    '{ROW_MODEL, ACT_GET, 32'h0000_0101, 31'h0000_0000, 1'b0, '0},
    '{ROW_MODEL, ACT_GET, 32'h0000_0000, 31'h0000_0000, 1'b0, '0}
  };

  logic             clk;
  logic             rst;
  logic             capacity_we;
  logic [CAP_W-1:0] capacity_wdata;

  lrukv_req_if req_ch ();
  lrukv_rsp_if rsp_ch ();

  lru_key_value_cache_top #(
    .MAX_ENTRIES(ENTRIES)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch.sink),
    .rsp           (rsp_ch.source),
    .capacity_we   (capacity_we),
    .capacity_wdata(capacity_wdata)
  );

  // Shadow copy of the cache: keys, values, valid bits, recency ranks
  // (0 = most recent), fill count and the capacity register.
  logic [KEY_W-1:0]   shadow_key   [ENTRIES];
  logic [VALUE_W-1:0] shadow_value [ENTRIES];
  bit                 shadow_valid [ENTRIES];
  int unsigned        shadow_rank  [ENTRIES];
  int unsigned        shadow_fill;
  logic [CAP_W-1:0]   shadow_capacity;

  // responses still owed by the block, oldest first
  lookup_result_t expected_results [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct;    // chance of a sender gap per cycle
  int unsigned rsp_stall_pct;   // chance of ready low per cycle
  logic        start_hold;      // kicks off the long receiver hold-off
  logic        hold_rsp;

  // Apply one request to the shadow cache and return the response it owes.
  function automatic lookup_result_t predict_lookup(
    input logic               act,
    input logic [KEY_W-1:0]   key,
    input logic [VALUE_W-1:0] value
  );
    lookup_result_t res;
    int             found;
    int             slot;
    int unsigned    eff_cap;
    int unsigned    pivot;
    int unsigned    oldest;
    res.hit        = 1'b0;
    res.read_value = MISS_VALUE;
    found          = -1;
    slot           = -1;
    oldest         = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_key[i] == key) found = i;
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (act == ACT_GET) begin
        res.read_value = {1'b0, shadow_value[found]};
      end else begin
        shadow_value[found] = value;
      end
      // promote: only entries more recent than the hit age
      pivot = shadow_rank[found];
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_valid[i] && i != found && shadow_rank[i] < pivot) shadow_rank[i]++;
      end
      shadow_rank[found] = 0;
    end else if (act == ACT_SET) begin
      eff_cap = (shadow_capacity == 0) ? 1 :
                (shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity;
      if (shadow_fill >= eff_cap) begin
        // evict the highest rank; lowest index wins a tie
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > oldest)) begin
            oldest = shadow_rank[i];
            slot   = i;
          end
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !shadow_valid[i]) slot = i;
        end
        shadow_valid[slot] = 1'b1;
        shadow_fill++;
      end
      shadow_key[slot]   = key;
      shadow_value[slot] = value;
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_valid[i] && i != slot) shadow_rank[i]++;
      end
      shadow_rank[slot] = 0;
    end
    return res;
  endfunction

  // Offer one request, optionally after random gaps, and hold it until
  // taken. The expectation is logged at the accepting edge. Called at a
  // rising edge, returns at the accepting edge.
  task automatic send_request(
    input logic               act,
    input logic [KEY_W-1:0]   key,
    input logic [VALUE_W-1:0] value,
    input bit                 use_typed,
    input lookup_result_t     typed
  );
    lookup_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.key    <= key;
    req_ch.value  <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    res = predict_lookup(act, key, value);
    expected_results.push_back(use_typed ? typed : res);
  endtask

  // Capacity writes only once every response is back, so the block is idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    capacity_we    <= 1'b1;
    capacity_wdata <= cap;
    @(posedge clk);
    capacity_we     <= 1'b0;
    shadow_capacity = cap;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing
  // requests and the block backs up into its input.
  initial begin : rsp_hold_off
    hold_rsp <= 1'b0;
    wait (start_hold === 1'b1);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // Response side: check what was taken at this edge, then pick ready.
  initial begin : rsp_monitor
    lookup_result_t want;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected response: hit %0b read_value %0h",
                 rsp_ch.hit, rsp_ch.read_value);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
            mismatches++;
          end
          if (rsp_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0h, got %0h",
                   want.read_value, rsp_ch.read_value);
            mismatches++;
          end
        end
      end
      rsp_ch.ready <= !rst && !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  initial begin : stimulus
    lookup_result_t     typed;
    logic [KEY_W-1:0]   key_pool [32];
    int unsigned        pool_size;
    logic               act;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;

    rst            <= 1'b1;
    capacity_we    <= 1'b0;
    capacity_wdata <= CAP_RESET;
    req_ch.valid   <= 1'b0;
    req_ch.action  <= ACT_GET;
    req_ch.key     <= '0;
    req_ch.value   <= '0;
    start_hold     <= 1'b0;
    src_idle_pct    = 0;
    rsp_stall_pct   = 0;

    // shadow cache mirrors reset: empty, capacity 16
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 0;
    end
    shadow_fill     = 0;
    shadow_capacity = CAP_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: walk the table.
    foreach (DIRECTED_STIM[r]) begin
      if (DIRECTED_STIM[r].kind == ROW_CFG) begin
        set_capacity(DIRECTED_STIM[r].value[CAP_W-1:0]);
      end else begin
        typed.hit        = DIRECTED_STIM[r].exp_hit;
        typed.read_value = DIRECTED_STIM[r].exp_read;
        send_request(DIRECTED_STIM[r].act, DIRECTED_STIM[r].key,
                     DIRECTED_STIM[r].value, DIRECTED_STIM[r].kind == ROW_TYPED, typed);
      end
    end

    // Random part: each phase sets a capacity and an idling mode, then runs
    // requests over a small key pool so gets and sets hit often and
    // evictions happen; some keys are fully random to force misses.
    typed = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_capacity(PHASE_CAPACITY[p]);
      case (p % 4)
        0: begin
          src_idle_pct  = 0;
          rsp_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 64;
          rsp_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          rsp_stall_pct = 64;
        end
        default: begin
          src_idle_pct  = 22;
          rsp_stall_pct = 22;
        end
      endcase
      if (p == PRESSURE_PHASE) start_hold <= 1'b1;

      pool_size = $urandom_range(24, 2);
      for (int k = 0; k < pool_size; k++) begin
        case ($urandom_range(3))
          0:       key_pool[k] = KEY_W'($urandom_range(31));
          1:       key_pool[k] = {1'b1, 31'($urandom_range(31))};
          default: key_pool[k] = KEY_W'($urandom);
        endcase
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        act = 1'($urandom_range(1));
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_size - 1)]
                                         : KEY_W'($urandom);
        case ($urandom_range(9))
          0:       value = '0;
          1:       value = '1;
          default: value = VALUE_W'($urandom);
        endcase
        send_request(act, key, value, 1'b0, typed);
      end
    end

    // Drain: every response back, then a latency's worth of quiet cycles.
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
